// ----- sv/fdc_pkg.sv -----
// Shared types, constants and the CRC-32 byte update for the frame deframer and checker.
// No dependencies; fdc_front, fdc_queue, fdc_back and the top level import this package.
package fdc_pkg;

  localparam int HDR_BYTES      = 20;
  localparam int CRC_HDR_BYTES  = 18;
  localparam int FOLD_SHIFT     = 16;
  localparam int HDR_IDX_W      = 5;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;

  localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
  localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;
  localparam logic [23:0] MAX_PAYLOAD_RST = 24'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_MAGIC      = 2'd0,
    CFG_PROTOCOL_VERSION = 2'd1,
    CFG_MAX_PAYLOAD      = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    VERDICT_OK = 2'd0,
    BAD_HEADER = 2'd1,
    BAD_SIZE   = 2'd2,
    BAD_CHECK  = 2'd3
  } verdict_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic        has_payload;
    logic [7:0]  payload;
    logic        has_verdict;
    verdict_t    code;
    logic [15:0] command;
    logic [15:0] sequence_no;
    logic [15:0] status;
    logic [15:0] flags;
    logic [23:0] length;
  } q_entry_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- sv/fdc_ifs.sv -----
// Handshake interfaces for the byte input channel and the result channel.
// No dependencies.
interface fdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_frame;

  modport source(output valid, data_byte, end_of_frame, input ready);
  modport sink(input valid, data_byte, end_of_frame, output ready);
endinterface

interface fdc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_data;
  logic [1:0]  verdict_code;
  logic [15:0] command_id;
  logic [15:0] sequence_no;
  logic [15:0] status_field;
  logic [15:0] flag_field;
  logic [23:0] payload_length;
  logic        last_result;

  modport source(output valid, result_kind, payload_data, verdict_code, command_id,
                 sequence_no, status_field, flag_field, payload_length, last_result,
                 input ready);
  modport sink(input valid, result_kind, payload_data, verdict_code, command_id,
               sequence_no, status_field, flag_field, payload_length, last_result,
               output ready);
endinterface

// ----- sv/fdc_front.sv -----
// Front end: accepts bytes, captures the header, runs the CRC and decides the verdict.
// Depends on fdc_pkg; holds the configuration registers.
module fdc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_end_of_frame,
  input  logic                          cfg_we,
  input  logic [fdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fdc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          q_ready,
  output logic                          push,
  output fdc_pkg::q_entry_t             push_entry
);
  import fdc_pkg::*;

  logic [31:0] frame_magic_r;
  logic [15:0] protocol_version_r;
  logic [23:0] max_payload_r;
  logic [31:0] count_r, count_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [7:0]  hdr_r [HDR_BYTES];
  logic [7:0]  hdr_nxt [HDR_BYTES];
  logic        accept;
  logic        in_header;
  logic        in_crc;
  logic [31:0] crc_fin;
  logic [15:0] fold;
  logic [31:0] magic;
  logic [15:0] version;
  logic [31:0] length;
  logic [15:0] rcv_check;
  logic        bad_header, bad_size, bad_check;
  verdict_t    code;

  assign in_ready  = q_ready;
  assign accept    = in_valid && q_ready;
  assign in_header = count_r < 32'(HDR_BYTES);
  assign in_crc    = (count_r < 32'(CRC_HDR_BYTES)) || !in_header;

  always_comb begin
    hdr_nxt = hdr_r;
    if (in_header) begin
      hdr_nxt[count_r[HDR_IDX_W-1:0]] = in_data_byte;
    end
  end

  assign count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + 32'd1;
  assign crc_nxt   = in_crc ? crc_byte(crc_r, in_data_byte) : crc_r;
  assign crc_fin   = ~crc_nxt;
  assign fold      = crc_fin[15:0] ^ crc_fin[FOLD_SHIFT +: 16];

  assign magic     = {hdr_nxt[3], hdr_nxt[2], hdr_nxt[1], hdr_nxt[0]};
  assign version   = {hdr_nxt[5], hdr_nxt[4]};
  assign length    = {hdr_nxt[17], hdr_nxt[16], hdr_nxt[15], hdr_nxt[14]};
  assign rcv_check = {hdr_nxt[19], hdr_nxt[18]};

  assign bad_header = (count_nxt < 32'(HDR_BYTES)) || (magic != frame_magic_r)
                      || (version != protocol_version_r);
  assign bad_size   = (length > {8'd0, max_payload_r})
                      || ({1'b0, count_nxt} != ({1'b0, length} + 33'(HDR_BYTES)));
  assign bad_check  = rcv_check != fold;

  always_comb begin
    priority if (bad_header) begin
      code = BAD_HEADER;
    end else if (bad_size) begin
      code = BAD_SIZE;
    end else if (bad_check) begin
      code = BAD_CHECK;
    end else begin
      code = VERDICT_OK;
    end
  end

  always_comb begin
    push_entry             = '0;
    push_entry.has_payload = !in_header;
    push_entry.payload     = in_header ? 8'd0 : in_data_byte;
    push_entry.has_verdict = in_end_of_frame;
    push_entry.code        = code;
    if (code == VERDICT_OK) begin
      push_entry.command     = {hdr_nxt[7], hdr_nxt[6]};
      push_entry.sequence_no = {hdr_nxt[9], hdr_nxt[8]};
      push_entry.status      = {hdr_nxt[11], hdr_nxt[10]};
      push_entry.flags       = {hdr_nxt[13], hdr_nxt[12]};
      push_entry.length      = length[23:0];
    end
  end

  assign push = accept && (!in_header || in_end_of_frame);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_magic_r      <= '0;
      protocol_version_r <= '0;
      max_payload_r      <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_MAGIC:      frame_magic_r      <= cfg_data;
        CFG_PROTOCOL_VERSION: protocol_version_r <= cfg_data[15:0];
        CFG_MAX_PAYLOAD:      max_payload_r      <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      crc_r   <= CRC_INIT;
    end else if (accept) begin
      if (in_end_of_frame) begin
        count_r <= '0;
        crc_r   <= CRC_INIT;
      end else begin
        count_r <= count_nxt;
        crc_r   <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_r <= hdr_nxt;
    end
  end

endmodule

// ----- sv/fdc_queue.sv -----
// Short queue between the front end and the result back end.
// Depends on fdc_pkg for the entry type.
module fdc_queue #(
  parameter int Depth = fdc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fdc_pkg::q_entry_t push_entry,
  output logic              not_full,
  input  logic              pop,
  output logic              not_empty,
  output fdc_pkg::q_entry_t head
);
  import fdc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  q_entry_t        mem [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign not_full  = cnt_r != CntW'(Depth);
  assign not_empty = cnt_r != '0;
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- sv/fdc_back.sv -----
// Back end: turns queue entries into payload and verdict beats in an output register.
// Depends on fdc_pkg and the result interface.
module fdc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  fdc_pkg::q_entry_t head,
  output logic              pop,
  fdc_out_if.source         out_ch
);
  import fdc_pkg::*;

  logic         out_valid_r;
  logic         kind_r;
  logic [7:0]   payload_r;
  verdict_t     code_r;
  logic [15:0]  command_r, sequence_r, status_r, flags_r;
  logic [23:0]  length_r;
  logic         sent_r, sent_nxt;
  logic         load;
  logic         emit_payload;

  assign load         = !out_valid_r || out_ch.ready;
  assign emit_payload = head.has_payload && !sent_r;
  assign pop          = load && q_valid && !(emit_payload && head.has_verdict);

  always_comb begin
    sent_nxt = sent_r;
    if (load && q_valid) begin
      sent_nxt = emit_payload && head.has_verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_r      <= 1'b0;
    end else begin
      sent_r <= sent_nxt;
      if (load) begin
        out_valid_r <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      if (emit_payload) begin
        kind_r     <= KIND_PAYLOAD;
        payload_r  <= head.payload;
        code_r     <= VERDICT_OK;
        command_r  <= '0;
        sequence_r <= '0;
        status_r   <= '0;
        flags_r    <= '0;
        length_r   <= '0;
      end else begin
        kind_r     <= KIND_VERDICT;
        payload_r  <= '0;
        code_r     <= head.code;
        command_r  <= head.command;
        sequence_r <= head.sequence_no;
        status_r   <= head.status;
        flags_r    <= head.flags;
        length_r   <= head.length;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_kind    = kind_r;
  assign out_ch.payload_data   = payload_r;
  assign out_ch.verdict_code   = code_r;
  assign out_ch.command_id     = command_r;
  assign out_ch.sequence_no    = sequence_r;
  assign out_ch.status_field   = status_r;
  assign out_ch.flag_field     = flags_r;
  assign out_ch.payload_length = length_r;
  assign out_ch.last_result    = kind_r;

endmodule

// ----- sv/frame_deframer_checker_unit.sv -----
// Top level of the frame deframer and checker: front end, queue and back end.
// Depends on fdc_pkg, fdc_ifs, fdc_front, fdc_queue and fdc_back.
//
//   Channel  Direction  Beat contents
//   in_ch    sink       data_byte, end_of_frame
//   out_ch   source     result_kind, payload_data, verdict, header fields, last_result
//   cfg_*    write      cfg_index selects magic, version or max payload; cfg_data
//
// One byte is accepted per cycle while the queue has room; the CRC update and header
// capture are registered as each byte is accepted. A byte that yields both a payload
// beat and a verdict stays at the queue head until both beats have gone out.
// Each result passes through the queue and then the output register. Reset is
// synchronous and needs no clearing pass.
// in_ch.ready drops only while the queue is full.
module frame_deframer_checker_unit #(
  parameter int QueueDepth = fdc_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fdc_in_if.sink                         in_ch,
  fdc_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [fdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fdc_pkg::*;

  logic     q_not_full;
  logic     q_not_empty;
  logic     push;
  logic     pop;
  q_entry_t push_entry;
  q_entry_t head;

  fdc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_data_byte    (in_ch.data_byte),
    .in_end_of_frame (in_ch.end_of_frame),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_ready         (q_not_full),
    .push            (push),
    .push_entry      (push_entry)
  );

  fdc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .not_full   (q_not_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  fdc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_not_empty),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.result_kind == KIND_PAYLOAD) |->
      (out_ch.verdict_code == VERDICT_OK) && (out_ch.payload_length == '0)
      && !out_ch.last_result)
    else $error("Payload beat carries verdict fields.");

  a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.result_kind == KIND_VERDICT) |->
      (out_ch.payload_data == '0) && out_ch.last_result)
    else $error("Verdict beat carries payload data or lacks the last flag.");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.verdict_code != VERDICT_OK) |->
      (out_ch.command_id == '0) && (out_ch.sequence_no == '0)
      && (out_ch.status_field == '0) && (out_ch.flag_field == '0))
    else $error("Error verdict carries header fields.");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("Result beat offered right after reset.");
`endif

endmodule
